/* design/gmvn_pkg.sv */
// Shared constants, types and the triangle offset table of the grid mesh
// vertex normal unit. Used by the multiplier, the top level and the checker; depends on nothing.
`default_nettype none
package gmvn_pkg;

  // Grid limits.
  localparam int MAX_SIDE  = 64;
  localparam int MAX_VERTS = 4096;
  localparam int ADDR_W    = $clog2(MAX_VERTS);

  // Field widths.
  localparam int IDX_W   = 12;
  localparam int COORD_W = 16;
  localparam int SIDE_W  = 7;
  localparam int VERT_W  = 3 * COORD_W;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // Request function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // Neighbor offsets relative to the requested vertex.
  typedef enum logic [2:0] {
    OFS_C  = 3'd0,
    OFS_UL = 3'd1,
    OFS_U  = 3'd2,
    OFS_L  = 3'd3,
    OFS_R  = 3'd4,
    OFS_D  = 3'd5,
    OFS_DR = 3'd6
  } ofs_t;

  localparam int NUM_TRI = 6;

  // Corner k of touching triangle tri_n, in face vector order (v1, v2, v3).
  function automatic ofs_t tri_ofs(input logic [2:0] tri_n, input logic [1:0] k);
    ofs_t o;
    o = OFS_C;
    case (tri_n)
      3'd0: o = (k == 2'd0) ? OFS_UL : (k == 2'd1) ? OFS_L : OFS_C;
      3'd1: o = (k == 2'd0) ? OFS_C  : (k == 2'd1) ? OFS_U : OFS_UL;
      3'd2: o = (k == 2'd0) ? OFS_U  : (k == 2'd1) ? OFS_C : OFS_R;
      3'd3: o = (k == 2'd0) ? OFS_D  : (k == 2'd1) ? OFS_C : OFS_L;
      3'd4: o = (k == 2'd0) ? OFS_C  : (k == 2'd1) ? OFS_D : OFS_DR;
      3'd5: o = (k == 2'd0) ? OFS_DR : (k == 2'd1) ? OFS_R : OFS_C;
      default: o = OFS_C;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

/* design/gmvn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the vertex store; depends on nothing.
`default_nettype none
module gmvn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/gmvn_mul.sv */
// Shared signed multiplier with a registered product, used for the cross
// products and the squared magnitudes. Depends on gmvn_pkg.
`default_nettype none
module gmvn_mul (
  input  wire logic                               clk,
  input  wire logic signed [gmvn_pkg::MUL_W-1:0]  a,
  input  wire logic signed [gmvn_pkg::MUL_W-1:0]  b,
  output logic      signed [gmvn_pkg::PROD_W-1:0] p
);

  // One product per cycle, available on the next cycle.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

/* design/grid_mesh_vertex_normal_unit.sv */
// Top level of the grid mesh vertex normal unit: sequencer, vertex store,
// shared multiplier and result register. Depends on gmvn_pkg, gmvn_ram, gmvn_mul.
//
// Usage:
// The input channel (in_valid/in_ready) carries one request: func selects a
// vertex write or a normal read, vertex_index is row * grid_width + column.
// A write is stored in the cycle it is accepted and gives no result.
// A read gives one result on the output channel (out_valid/out_ready): the
// unit normal in Q1.14 and a status code.
// The configuration channel (cfg_valid/cfg_ready) writes grid_width or
// grid_height; it is always ready and must be used only while idle.
// A write leaves the input ready; a read holds it until its result is loaded.
// A read first checks the index against the grid and, if it is outside, goes
// straight to the output. Otherwise an index divider gives row and column,
// each of up to six touching faces takes three store reads and six products
// through the one shared multiplier, missing faces are skipped, and a zero
// face sum ends the read. Else the magnitudes are shifted down, squared and
// normalized bit-serially, each bit in a trial phase and a decision phase.
// A finished result waits in the output register and the next request is
// accepted meanwhile; a second result holds the sequencer, and with it the
// input, until the receiver takes the first one.
// Reset clears the sequencer and the output valid and sets both grid sides
// to 64. The vertex store is not cleared.
`default_nettype none
module grid_mesh_vertex_normal_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 func,
  input  wire logic [11:0]          vertex_index,
  input  wire logic signed [15:0]   pos_x,
  input  wire logic signed [15:0]   pos_y,
  input  wire logic signed [15:0]   pos_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [15:0]        normal_x,
  output logic signed [15:0]        normal_y,
  output logic signed [15:0]        normal_z,
  output logic [1:0]                status,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [6:0]           cfg_data
);

  localparam int SUM_W = 38;
  localparam int MAG_W = 36;
  localparam int Q_W   = 37;
  localparam int MSQ_W = 34;
  localparam int KQ_W  = 52;
  localparam int P_W   = 68;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_TSEL  = 11'b00000001000,
    S_FETCH = 11'b00000010000,
    S_CROSS = 11'b00000100000,
    S_MAG   = 11'b00001000000,
    S_SHIFT = 11'b00010000000,
    S_SQ    = 11'b00100000000,
    S_UNIT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  logic [6:0]  grid_w;
  logic [6:0]  grid_h;
  logic [11:0] idx;
  logic [7:0]  rem;
  logic [11:0] quo;
  logic [3:0]  dcnt;
  logic [2:0]  tri_n;
  logic [1:0]  fk;
  logic [2:0]  cs;
  logic [1:0]  sqc;
  logic [1:0]  comp;
  logic [3:0]  bit_n;
  logic        ph;
  logic [47:0] vtx [3];
  logic signed [SUM_W-1:0] sum [3];
  logic [MAG_W-1:0] mag [3];
  logic [MSQ_W-1:0] msq [3];
  logic [Q_W-1:0]   qsum;
  logic [KQ_W-1:0]  kq;
  logic [P_W-1:0]   pacc;
  logic [P_W-1:0]   ptrial;
  logic [14:0]      kval;
  logic signed [15:0] nrm [3];
  logic [1:0]       res_status;

  // Store and multiplier hookup.
  logic              ram_we;
  logic [gmvn_pkg::ADDR_W-1:0] ram_waddr;
  logic [gmvn_pkg::ADDR_W-1:0] ram_raddr;
  logic [gmvn_pkg::VERT_W-1:0] ram_rdata;
  logic signed [gmvn_pkg::MUL_W-1:0]  mul_a;
  logic signed [gmvn_pkg::MUL_W-1:0]  mul_b;
  logic signed [gmvn_pkg::PROD_W-1:0] mul_p;

  logic in_fire;
  logic out_load;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  assign ram_we    = in_fire && (func == gmvn_pkg::FUNC_WRITE) &&
                     ({1'b0, vertex_index} < gmvn_pkg::MAX_VERTS);
  assign ram_waddr = gmvn_pkg::ADDR_W'(vertex_index);

  gmvn_ram #(
    .WIDTH(gmvn_pkg::VERT_W),
    .DEPTH(gmvn_pkg::MAX_VERTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({pos_x, pos_y, pos_z}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gmvn_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  // Grid bounds check.
  logic [13:0] nverts;
  logic        outside;
  assign nverts  = {7'd0, grid_w} * {7'd0, grid_h};
  assign outside = (grid_w > gmvn_pkg::MAX_SIDE) || (grid_h > gmvn_pkg::MAX_SIDE) ||
                   (nverts > gmvn_pkg::MAX_VERTS) || ({2'b00, idx} >= nverts);

  // One restoring divider step.
  logic [7:0] div_trial;
  logic       div_ge;
  assign div_trial = {rem[6:0], idx[dcnt]};
  assign div_ge    = div_trial >= {1'b0, grid_w};

  // Which touching triangles exist for row quo and column rem.
  logic has_up, has_left, has_down, has_right, tri_ok;
  assign has_up    = (quo != 12'd0);
  assign has_left  = (rem != 8'd0);
  assign has_down  = ({1'b0, quo} + 13'd1) < {6'd0, grid_h};
  assign has_right = ({1'b0, rem} + 9'd1) < {2'd0, grid_w};
  always_comb begin
    case (tri_n)
      3'd0, 3'd1: tri_ok = has_up && has_left;
      3'd2:       tri_ok = has_up && has_right;
      3'd3:       tri_ok = has_down && has_left;
      3'd4, 3'd5: tri_ok = has_down && has_right;
      default:    tri_ok = 1'b0;
    endcase
  end

  // Address of the triangle corner being fetched.
  logic [11:0] w12;
  logic [11:0] corner_addr;
  assign w12 = {5'd0, grid_w};
  always_comb begin
    case (gmvn_pkg::tri_ofs(tri_n, fk))
      gmvn_pkg::OFS_UL: corner_addr = idx - w12 - 12'd1;
      gmvn_pkg::OFS_U:  corner_addr = idx - w12;
      gmvn_pkg::OFS_L:  corner_addr = idx - 12'd1;
      gmvn_pkg::OFS_R:  corner_addr = idx + 12'd1;
      gmvn_pkg::OFS_D:  corner_addr = idx + w12;
      gmvn_pkg::OFS_DR: corner_addr = idx + w12 + 12'd1;
      default:          corner_addr = idx;
    endcase
  end
  assign ram_raddr = gmvn_pkg::ADDR_W'(corner_addr);

  // Edge vectors d1 = v1 - v3 and d2 = v3 - v2.
  logic signed [16:0] d1x, d1y, d1z, d2x, d2y, d2z;
  assign d1x = 17'(signed'(vtx[0][47:32])) - 17'(signed'(vtx[2][47:32]));
  assign d1y = 17'(signed'(vtx[0][31:16])) - 17'(signed'(vtx[2][31:16]));
  assign d1z = 17'(signed'(vtx[0][15:0]))  - 17'(signed'(vtx[2][15:0]));
  assign d2x = 17'(signed'(vtx[2][47:32])) - 17'(signed'(vtx[1][47:32]));
  assign d2y = 17'(signed'(vtx[2][31:16])) - 17'(signed'(vtx[1][31:16]));
  assign d2z = 17'(signed'(vtx[2][15:0]))  - 17'(signed'(vtx[1][15:0]));

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      case (cs)
        3'd0: begin mul_a = 18'(d1y); mul_b = 18'(d2z); end
        3'd1: begin mul_a = 18'(d1z); mul_b = 18'(d2y); end
        3'd2: begin mul_a = 18'(d1z); mul_b = 18'(d2x); end
        3'd3: begin mul_a = 18'(d1x); mul_b = 18'(d2z); end
        3'd4: begin mul_a = 18'(d1x); mul_b = 18'(d2y); end
        3'd5: begin mul_a = 18'(d1y); mul_b = 18'(d2x); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if ((state == S_SQ) && (sqc != 2'd3)) begin
      mul_a = {1'b0, mag[sqc][16:0]};
      mul_b = {1'b0, mag[sqc][16:0]};
    end
  end

  // Product extended to the accumulator width.
  logic signed [SUM_W-1:0] prod_ext;
  assign prod_ext = {{(SUM_W - gmvn_pkg::PROD_W){mul_p[gmvn_pkg::PROD_W-1]}}, mul_p};

  // Magnitudes of the face sum.
  logic [MAG_W-1:0] abs_s [3];
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      abs_s[t] = sum[t][SUM_W-1] ? MAG_W'(-sum[t]) : MAG_W'(sum[t]);
    end
  end

  logic mag_big;
  assign mag_big = (mag[0][MAG_W-1:17] != '0) || (mag[1][MAG_W-1:17] != '0) ||
                   (mag[2][MAG_W-1:17] != '0);

  // Normalization trial and bound.
  logic [P_W-1:0] rhs;
  logic [P_W-1:0] trial_sum;
  logic [14:0]    kbit;
  logic [14:0]    knew;
  logic           take;
  assign rhs       = {6'd0, msq[comp], 28'd0};
  assign trial_sum = pacc + (P_W'(kq) << (bit_n + 4'd1)) + (P_W'(qsum) << {bit_n, 1'b0});
  assign kbit      = 15'd1 << bit_n;
  assign take      = (ptrial <= rhs);
  assign knew      = take ? (kval | kbit) : kval;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grid_w    <= 7'd64;
      grid_h    <= 7'd64;
      out_valid <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmvn_pkg::CFG_WIDTH) begin
          grid_w <= cfg_data;
        end else begin
          grid_h <= cfg_data;
        end
      end

      // Output register: loaded with a new result or emptied by the receiver.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && (func == gmvn_pkg::FUNC_READ)) begin
            idx   <= vertex_index;
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          nrm[0] <= '0;
          nrm[1] <= '0;
          nrm[2] <= '0;
          if (outside) begin
            res_status <= gmvn_pkg::ST_OUTSIDE;
            state      <= S_OUT;
          end else begin
            rem   <= '0;
            quo   <= '0;
            dcnt  <= 4'd11;
            state <= S_DIV;
          end
        end

        // Row and column of the vertex, one quotient bit a cycle.
        S_DIV: begin
          rem <= div_ge ? (div_trial - {1'b0, grid_w}) : div_trial;
          quo <= {quo[10:0], div_ge};
          if (dcnt == 4'd0) begin
            tri_n  <= '0;
            sum[0] <= '0;
            sum[1] <= '0;
            sum[2] <= '0;
            state  <= S_TSEL;
          end else begin
            dcnt <= dcnt - 4'd1;
          end
        end

        S_TSEL: begin
          if (tri_n == 3'(gmvn_pkg::NUM_TRI)) begin
            state <= S_MAG;
          end else if (tri_ok) begin
            fk    <= '0;
            state <= S_FETCH;
          end else begin
            tri_n <= tri_n + 3'd1;
          end
        end

        // Three corner reads, each data word captured in the cycle after its address.
        S_FETCH: begin
          if (fk != 2'd0) begin
            vtx[fk - 2'd1] <= ram_rdata;
          end
          if (fk == 2'd3) begin
            cs    <= '0;
            state <= S_CROSS;
          end else begin
            fk <= fk + 2'd1;
          end
        end

        // Six products, each added in the cycle after it is issued.
        S_CROSS: begin
          case (cs)
            3'd1: sum[0] <= sum[0] + prod_ext;
            3'd2: sum[0] <= sum[0] - prod_ext;
            3'd3: sum[1] <= sum[1] + prod_ext;
            3'd4: sum[1] <= sum[1] - prod_ext;
            3'd5: sum[2] <= sum[2] + prod_ext;
            3'd6: sum[2] <= sum[2] - prod_ext;
            default: ;
          endcase
          if (cs == 3'd6) begin
            tri_n <= tri_n + 3'd1;
            state <= S_TSEL;
          end else begin
            cs <= cs + 3'd1;
          end
        end

        S_MAG: begin
          mag[0] <= abs_s[0];
          mag[1] <= abs_s[1];
          mag[2] <= abs_s[2];
          if ((sum[0] == '0) && (sum[1] == '0) && (sum[2] == '0)) begin
            res_status <= gmvn_pkg::ST_ZERO;
            state      <= S_OUT;
          end else begin
            state <= S_SHIFT;
          end
        end

        // Scale all magnitudes down together until each fits in 17 bits.
        S_SHIFT: begin
          if (mag_big) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            sqc   <= '0;
            qsum  <= '0;
            state <= S_SQ;
          end
        end

        // Squares of the scaled magnitudes and their sum.
        S_SQ: begin
          if (sqc != 2'd0) begin
            msq[sqc - 2'd1] <= MSQ_W'(mul_p);
            qsum            <= qsum + Q_W'(mul_p);
          end
          if (sqc == 2'd3) begin
            comp  <= '0;
            bit_n <= 4'd14;
            ph    <= 1'b0;
            kval  <= '0;
            kq    <= '0;
            pacc  <= '0;
            state <= S_UNIT;
          end else begin
            sqc <= sqc + 2'd1;
          end
        end

        // Largest k with k*k*Q <= m*m*2^28, one bit at a time: a trial phase, then a decision phase.
        S_UNIT: begin
          if (!ph) begin
            ptrial <= trial_sum;
            ph     <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (bit_n == 4'd0) begin
              nrm[comp] <= (sum[comp] > 0) ? -16'(knew) : 16'(knew);
              kval  <= '0;
              kq    <= '0;
              pacc  <= '0;
              bit_n <= 4'd14;
              if (comp == 2'd2) begin
                res_status <= gmvn_pkg::ST_OK;
                state      <= S_OUT;
              end else begin
                comp <= comp + 2'd1;
              end
            end else begin
              if (take) begin
                pacc <= ptrial;
                kq   <= kq + (KQ_W'(qsum) << bit_n);
              end
              kval  <= knew;
              bit_n <= bit_n - 4'd1;
            end
          end
        end

        // Load the output register once it is free.
        S_OUT: begin
          if (out_load) begin
            normal_x <= nrm[0];
            normal_y <= nrm[1];
            normal_z <= nrm[2];
            status   <= res_status;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/gmvn_checker.sv */
// Port-level checks of the grid mesh vertex normal unit and the bind that
// attaches them to the top level. Depends on grid_mesh_vertex_normal_unit and gmvn_pkg.
`default_nettype none
module gmvn_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] normal_x,
  input wire logic signed [15:0] normal_y,
  input wire logic signed [15:0] normal_z,
  input wire logic [1:0]         status
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y) &&
    $stable(normal_z) && $stable(status))
    else $error("stalled result changed");

  // Error results carry zero normals.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != gmvn_pkg::ST_OK) |->
    (normal_x == 0) && (normal_y == 0) && (normal_z == 0))
    else $error("error result with nonzero normal");

  // Unit components stay within one in Q1.14.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x >= -16384) && (normal_x <= 16384) && (normal_y >= -16384) &&
    (normal_y <= 16384) && (normal_z >= -16384) && (normal_z <= 16384))
    else $error("normal component out of range");

  // The unused status code never appears.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("invalid status code");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_mesh_vertex_normal_unit gmvn_checker u_gmvn_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .normal_x (normal_x),
  .normal_y (normal_y),
  .normal_z (normal_z),
  .status   (status)
);
`default_nettype wire
